[hdl/tbu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbu_pkg
// shared widths, constants and types of the timer based 8n1 uart
// ----------------------------------------------------------------------------
package tbu_pkg;

   localparam int TIMER_W    = 16;
   localparam int FRAME_W    = 11;
   localparam int RX_SHIFT_W = 10;
   localparam int RX_COUNT_W = 4;
   localparam int BYTE_W     = 8;

   localparam logic [TIMER_W-1:0]    RESET_PERIOD  = 16'd416;
   localparam logic [FRAME_W-1:0]    TX_IDLE_FRAME = 11'd1;
   localparam logic [RX_COUNT_W-1:0] RX_FRAME_BITS = 4'd10;

   // per tick control handed from the timer to both directions
   typedef struct packed {
      logic               step;
      logic               wrap;
      logic [TIMER_W-1:0] timer;
      logic [TIMER_W-1:0] period;
   } tick_type;

   typedef struct packed {
      logic line;
      logic take;
   } tx_result_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } rx_result_type;

endpackage

[hdl/tbu_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbu channel interfaces
// valid/ready channels for tick transactions, results and the period register
// ----------------------------------------------------------------------------
interface tbu_req_if;
   logic                      valid;
   logic                      ready;
   logic                      rx_pin;
   logic                      tx_valid;
   logic [tbu_pkg::BYTE_W-1:0] tx_byte;

   modport source (output valid, output rx_pin, output tx_valid, output tx_byte,
                   input ready);
   modport sink   (input valid, input rx_pin, input tx_valid, input tx_byte,
                   output ready);
endinterface

interface tbu_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      tx_line;
   logic                      tx_take;
   logic                      rx_valid;
   logic [tbu_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output tx_line, output tx_take, output rx_valid,
                   output rx_byte, input ready);
   modport sink   (input valid, input tx_line, input tx_take, input rx_valid,
                   input rx_byte, output ready);
endinterface

interface tbu_csr_if;
   logic                        valid;
   logic                        ready;
   logic [tbu_pkg::TIMER_W-1:0] bit_period;

   modport source (output valid, output bit_period, input ready);
   modport sink   (input valid, input bit_period, output ready);
endinterface

[hdl/tbu_tx.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbu_tx
// transmit frame shifter, steps once per timer wrap while enabled
// ----------------------------------------------------------------------------
module tbu_tx (
   input  logic                       clock,
   input  logic                       reset,
   input  tbu_pkg::tick_type          tick,
   input  logic                       tx_valid,
   input  logic [tbu_pkg::BYTE_W-1:0] tx_byte,
   output tbu_pkg::tx_result_type     result
);

   logic [tbu_pkg::FRAME_W-1:0] frame_ff, frame_in;
   logic                        enabled_ff, enabled_in;
   logic                        level_ff, level_in;
   logic                        take;
   logic                        enabled_now;

   always_comb begin
      enabled_now = enabled_ff | tx_valid;
      frame_in    = frame_ff;
      enabled_in  = enabled_now;
      level_in    = level_ff;
      take        = 1'b0;
      if (tick.wrap && enabled_now) begin
         level_in = frame_ff[0];
         if (frame_ff == tbu_pkg::TX_IDLE_FRAME) begin
            if (tx_valid) begin
               frame_in = {2'b11, tx_byte, 1'b0};
               take     = 1'b1;
            end else begin
               enabled_in = 1'b0;
            end
         end else begin
            frame_in = {1'b0, frame_ff[tbu_pkg::FRAME_W-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff   <= tbu_pkg::TX_IDLE_FRAME;
         enabled_ff <= 1'b0;
         level_ff   <= 1'b1;
      end else if (tick.step) begin
         frame_ff   <= frame_in;
         enabled_ff <= enabled_in;
         level_ff   <= level_in;
      end
   end

   assign result.line = level_in;
   assign result.take = take;

endmodule

[hdl/tbu_rx.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbu_rx
// start edge detection, mid-bit sampling and frame check
// ----------------------------------------------------------------------------
module tbu_rx (
   input  logic                   clock,
   input  logic                   reset,
   input  tbu_pkg::tick_type      tick,
   input  logic                   rx_pin,
   output tbu_pkg::rx_result_type result
);

   logic                           busy_ff, busy_in;
   logic                           prev_ff;
   logic [tbu_pkg::TIMER_W-1:0]    point_ff, point_in;
   logic [tbu_pkg::RX_SHIFT_W-1:0] shift_ff, shift_in;
   logic [tbu_pkg::RX_COUNT_W-1:0] count_ff, count_in;
   logic [tbu_pkg::RX_SHIFT_W-1:0] sample;
   logic [tbu_pkg::RX_COUNT_W-1:0] count_next;
   logic [tbu_pkg::TIMER_W:0]      point_sum;
   logic [tbu_pkg::TIMER_W:0]      point_wrap;
   logic                           done_ok;

   always_comb begin
      sample     = {rx_pin, shift_ff[tbu_pkg::RX_SHIFT_W-1:1]};
      count_next = count_ff + 1'b1;
      point_sum  = {1'b0, tick.timer} + {2'b00, tick.period[tbu_pkg::TIMER_W-1:1]};
      point_wrap = point_sum - {1'b0, tick.period};
      busy_in    = busy_ff;
      point_in   = point_ff;
      shift_in   = shift_ff;
      count_in   = count_ff;
      done_ok    = 1'b0;
      if (busy_ff) begin
         if (tick.timer == point_ff) begin
            if (count_next == tbu_pkg::RX_FRAME_BITS) begin
               // start low and stop high, otherwise dropped
               done_ok = ~sample[0] & sample[tbu_pkg::RX_SHIFT_W-1];
               busy_in = 1'b0;
            end else begin
               count_in = count_next;
               shift_in = sample;
            end
         end
      end else if (prev_ff && !rx_pin) begin
         if (point_sum >= {1'b0, tick.period}) begin
            point_in = point_wrap[tbu_pkg::TIMER_W-1:0];
         end else begin
            point_in = point_sum[tbu_pkg::TIMER_W-1:0];
         end
         shift_in = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         prev_ff  <= 1'b1;
         point_ff <= '0;
         shift_ff <= '0;
         count_ff <= '0;
      end else if (tick.step) begin
         busy_ff  <= busy_in;
         prev_ff  <= rx_pin;
         point_ff <= point_in;
         shift_ff <= shift_in;
         count_ff <= count_in;
      end
   end

   assign result.valid = done_ok;
   assign result.data  = done_ok ? sample[tbu_pkg::BYTE_W:1] : '0;

endmodule

[hdl/timer_based_uart_8n1.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_based_uart_8n1
// 8n1 uart transmitter and receiver paced by a shared bit timer
// ----------------------------------------------------------------------------
// usage
//   req_bus : one transaction per clock tick of the uart, carrying the sampled
//             rx pin level and an optional transmit byte offer
//   rsp_bus : one transaction per request: tx line level, byte taken flag and
//             a received byte with its valid flag
//   csr_bus : write of bit_period (uart ticks per serial bit minus one), always
//             ready; write it only while no request is in flight
//   path    : an accepted request waits in the input register until the result
//             register has room; its response is then registered there for rsp_bus
//   rate    : one transaction per cycle while rsp_bus does not stall; the bit
//             timer, tx frame and rx sampler state update on each processed tick
//   reset   : timer at zero, transmitter idle with line high, receiver
//             waiting for a start edge, bit_period back to 416
//   stall   : a held response keeps the input register full; one more request
//             is taken, then req_bus.ready drops until rsp_bus drains
// ----------------------------------------------------------------------------
module timer_based_uart_8n1 (
   input logic       clock,
   input logic       reset,
   tbu_req_if.sink   req_bus,
   tbu_rsp_if.source rsp_bus,
   tbu_csr_if.sink   csr_bus
);

   // input register
   logic                       in_valid_ff;
   logic                       in_rx_pin_ff;
   logic                       in_tx_valid_ff;
   logic [tbu_pkg::BYTE_W-1:0] in_tx_byte_ff;

   // result register
   logic                       out_valid_ff;
   logic                       out_tx_line_ff;
   logic                       out_tx_take_ff;
   logic                       out_rx_valid_ff;
   logic [tbu_pkg::BYTE_W-1:0] out_rx_byte_ff;

   logic [tbu_pkg::TIMER_W-1:0] period_ff;
   logic [tbu_pkg::TIMER_W-1:0] timer_ff, timer_in;

   logic                   advance;
   tbu_pkg::tick_type      tick;
   tbu_pkg::tx_result_type tx_res;
   tbu_pkg::rx_result_type rx_res;

   // the tick is processed when the result register has room
   assign advance = in_valid_ff & (~out_valid_ff | rsp_bus.ready);
   assign req_bus.ready = ~in_valid_ff | advance;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_rx_pin_ff   <= req_bus.rx_pin;
         in_tx_valid_ff <= req_bus.tx_valid;
         in_tx_byte_ff  <= req_bus.tx_byte;
      end
   end

   // bit period register
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= tbu_pkg::RESET_PERIOD;
      end else if (csr_bus.valid) begin
         period_ff <= csr_bus.bit_period;
      end
   end

   // shared bit timer, wraps only on equality so a lowered top runs to all ones
   always_comb begin
      tick.step   = advance;
      tick.timer  = timer_ff;
      tick.period = period_ff;
      tick.wrap   = (timer_ff == period_ff);
      timer_in    = tick.wrap ? '0 : timer_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= '0;
      end else if (advance) begin
         timer_ff <= timer_in;
      end
   end

   tbu_tx u_tx (
      .clock    (clock),
      .reset    (reset),
      .tick     (tick),
      .tx_valid (in_tx_valid_ff),
      .tx_byte  (in_tx_byte_ff),
      .result   (tx_res)
   );

   tbu_rx u_rx (
      .clock  (clock),
      .reset  (reset),
      .tick   (tick),
      .rx_pin (in_rx_pin_ff),
      .result (rx_res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_tx_line_ff  <= tx_res.line;
         out_tx_take_ff  <= tx_res.take;
         out_rx_valid_ff <= rx_res.valid;
         out_rx_byte_ff  <= rx_res.data;
      end
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.tx_line  = out_tx_line_ff;
   assign rsp_bus.tx_take  = out_tx_take_ff;
   assign rsp_bus.rx_valid = out_rx_valid_ff;
   assign rsp_bus.rx_byte  = out_rx_byte_ff;

   // a byte is taken into the frame only on a timer wrap
   a_take_on_wrap : assert property (@(posedge clock) disable iff (reset)
      (advance && tx_res.take) |-> tick.wrap)
      else $error("tx byte taken away from timer wrap");

   // a held result is not dropped
   a_hold_result : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready) |=> out_valid_ff)
      else $error("stalled result lost");

   // a pending tick is not dropped while the output stalls
   a_hold_tick : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("pending tick lost");

   // no received data without a valid frame
   a_rx_quiet : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_rx_valid_ff) |-> (out_rx_byte_ff == '0))
      else $error("rx byte nonzero without rx valid");

endmodule

[sim/tbu_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbu_check
// watches the tick, response and period channels of the timer based uart,
// predicts every response from its own copy of the uart state and compares
// ----------------------------------------------------------------------------
module tbu_check
   import tbu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tbu_req_if          req_mon,
   tbu_rsp_if          rsp_mon,
   tbu_csr_if          csr_mon,
   output int unsigned mismatches,
   output int unsigned waiting,
   output int unsigned rx_bytes_seen,
   output int unsigned tx_takes_seen
);

   typedef struct packed {
      tx_result_type tx;
      rx_result_type rx;
   } tick_result_type;

   // predicted uart state
   logic [TIMER_W-1:0]    line_period = RESET_PERIOD;
   logic [TIMER_W-1:0]    timer_now   = '0;
   logic [FRAME_W-1:0]    tx_shifter  = TX_IDLE_FRAME;
   logic                  tx_on       = 1'b0;
   logic                  tx_out      = 1'b1;
   logic                  rx_active   = 1'b0;
   logic                  rx_last_pin = 1'b1;
   logic [TIMER_W-1:0]    rx_mid      = '0;
   logic [RX_SHIFT_W-1:0] rx_seen     = '0;
   logic [RX_COUNT_W-1:0] rx_bits     = '0;

   tick_result_type tick_results_due[$];
   int unsigned     fail_total = 0;
   int unsigned     rsp_index  = 0;
   int unsigned     rx_total   = 0;
   int unsigned     take_total = 0;

   task automatic note_mismatch(input string what, input logic [7:0] got,
                                input logic [7:0] want);
      $display("%0t response %0d: %s is %0h, predicted %0h", $time, rsp_index, what,
               got, want);
      fail_total++;
   endtask

   // one uart tick, every decision taken on the timer value at its start
   function automatic tick_result_type uart_tick(input logic pin, input logic offer,
                                                 input logic [BYTE_W-1:0] data);
      tick_result_type       r;
      logic [TIMER_W-1:0]    t;
      logic [TIMER_W:0]      mid;
      logic [RX_SHIFT_W-1:0] word;
      logic [RX_COUNT_W-1:0] count;
      r = '0;
      t = timer_now;
      if (offer)
         tx_on = 1'b1;
      if (t == line_period && tx_on) begin
         tx_out = tx_shifter[0];
         if (tx_shifter == TX_IDLE_FRAME) begin
            if (offer) begin
               tx_shifter = {2'b11, data, 1'b0};
               r.tx.take = 1'b1;
            end else begin
               tx_on = 1'b0;
            end
         end else begin
            tx_shifter = tx_shifter >> 1;
         end
      end
      if (rx_active) begin
         if (t == rx_mid) begin
            word  = {pin, rx_seen[RX_SHIFT_W-1:1]};
            count = rx_bits + 1'b1;
            if (count == RX_FRAME_BITS) begin
               // start bit low and stop bit high, else dropped
               if (!word[0] && word[RX_SHIFT_W-1]) begin
                  r.rx.valid = 1'b1;
                  r.rx.data  = word[BYTE_W:1];
               end
               rx_active = 1'b0;
            end else begin
               rx_bits = count;
               rx_seen = word;
            end
         end
      end else if (rx_last_pin && !pin) begin
         mid = {1'b0, t} + (line_period >> 1);
         if (mid >= {1'b0, line_period})
            mid = mid - line_period;
         rx_mid    = mid[TIMER_W-1:0];
         rx_seen   = '0;
         rx_bits   = '0;
         rx_active = 1'b1;
      end
      timer_now   = (t == line_period) ? '0 : t + 1'b1;
      rx_last_pin = pin;
      r.tx.line   = tx_out;
      return r;
   endfunction

   always @(posedge clock) begin
      tick_result_type want;
      if (reset) begin
         line_period = RESET_PERIOD;
         timer_now   = '0;
         tx_shifter  = TX_IDLE_FRAME;
         tx_on       = 1'b0;
         tx_out      = 1'b1;
         rx_active   = 1'b0;
         rx_last_pin = 1'b1;
         rx_mid      = '0;
         rx_seen     = '0;
         rx_bits     = '0;
         tick_results_due.delete();
      end else begin
         // compare before queueing so a response cannot match its own request
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (tick_results_due.size() == 0) begin
               note_mismatch("unrequested response", 8'h00, 8'h00);
            end else begin
               want = tick_results_due.pop_front();
               if (rsp_mon.tx_line !== want.tx.line)
                  note_mismatch("tx_line", 8'(rsp_mon.tx_line), 8'(want.tx.line));
               if (rsp_mon.tx_take !== want.tx.take)
                  note_mismatch("tx_take", 8'(rsp_mon.tx_take), 8'(want.tx.take));
               if (rsp_mon.rx_valid !== want.rx.valid)
                  note_mismatch("rx_valid", 8'(rsp_mon.rx_valid), 8'(want.rx.valid));
               if (rsp_mon.rx_byte !== want.rx.data)
                  note_mismatch("rx_byte", rsp_mon.rx_byte, want.rx.data);
               if (want.rx.valid)
                  rx_total++;
               if (want.tx.take)
                  take_total++;
            end
            rsp_index++;
         end
         if (req_mon.valid && req_mon.ready)
            tick_results_due.push_back(uart_tick(req_mon.rx_pin, req_mon.tx_valid,
                                                 req_mon.tx_byte));
         if (csr_mon.valid && csr_mon.ready)
            line_period = csr_mon.bit_period;
      end
      mismatches    <= fail_total;
      waiting       <= tick_results_due.size();
      rx_bytes_seen <= rx_total;
      tx_takes_seen <= take_total;
   end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives uart ticks into the timer based 8n1 uart: framed serial traffic on
// the rx pin with random bytes, broken frames and noise, plus transmit byte
// offers, over a range of bit periods and idle patterns; tbu_check predicts
// and compares every response
// ----------------------------------------------------------------------------
module tb;
   import tbu_pkg::*;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned SETTLE_CYCLES = 4;     // covers the result register, with margin
   localparam int unsigned HOLD_CYCLES   = 400;   // long response back-pressure stretch
   localparam int unsigned DIRECT_TICKS  = 24;

   // directed pattern at period 0 (one tick per bit): idle, a good frame of
   // all ones, a frame of zeros with a low stop bit, idle again
   localparam logic [DIRECT_TICKS-1:0] DIRECT_PIN   = 24'b1_00000000000_111111111_001;
   // offers: a take, two offers without take, later two more
   localparam logic [DIRECT_TICKS-1:0] DIRECT_OFFER = 24'h00300E;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tbu_req_if req_bus ();
   tbu_rsp_if rsp_bus ();
   tbu_csr_if csr_bus ();

   int unsigned mismatches;
   int unsigned waiting;
   int unsigned rx_bytes_seen;
   int unsigned tx_takes_seen;

   idle_mode_type idle_mode    = IDLE_NONE;
   int unsigned hold_asks      = 0;
   int unsigned holds_served   = 0;
   int unsigned hold_left      = 0;
   int unsigned cycle_count    = 0;
   int unsigned ticks_sent     = 0;
   int unsigned settings_used  = 0;
   logic        line_plan[$];   // rx pin levels still to be sent

   timer_based_uart_8n1 DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   tbu_check u_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_mon       (csr_bus),
      .mismatches    (mismatches),
      .waiting       (waiting),
      .rx_bytes_seen (rx_bytes_seen),
      .tx_takes_seen (tx_takes_seen)
   );

   always #2 clock = ~clock;

   // run limit; a hung handshake ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // response side: a requested long hold first, else stall per idle mode
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (holds_served != hold_asks) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= HOLD_CYCLES;
         holds_served  <= holds_served + 1;
      end else begin
         case (idle_mode)
            IDLE_RECV: rsp_bus.ready <= ($urandom_range(99) >= 88);
            IDLE_BOTH: rsp_bus.ready <= ($urandom_range(99) >= 23);
            default:   rsp_bus.ready <= 1'b1;
         endcase
      end
   end

   // one tick transaction; valid stays up after acceptance so back-to-back
   // transactions never lower and raise it in the same step
   task automatic send_tick(input logic pin, input logic offer, input logic [BYTE_W-1:0] data);
      int unsigned idle_pct;
      idle_pct = (idle_mode == IDLE_SEND) ? 88 : (idle_mode == IDLE_BOTH) ? 23 : 0;
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.rx_pin   <= pin;
      req_bus.tx_valid <= offer;
      req_bus.tx_byte  <= data;
      do
         @(posedge clock);
      while (!req_bus.ready);
      ticks_sent++;
   endtask

   // stop offering, wait for every response, then let the block go quiet
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_period(input logic [TIMER_W-1:0] period);
      csr_bus.valid      <= 1'b1;
      csr_bus.bit_period <= period;
      do
         @(posedge clock);
      while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   // queue the next stretch of rx line activity for the given bit period
   function automatic void plan_line(input logic [TIMER_W-1:0] period);
      int unsigned bit_len;
      int unsigned bit_ticks;
      int unsigned roll;
      int unsigned k;
      logic        level;
      logic [9:0]  frame;
      bit_len = period + 1;
      roll    = $urandom_range(99);
      if (bit_len > 1000) begin
         // bits too long for whole frames: idle high, then rough random levels
         repeat (5) line_plan.push_back(1'b1);
         repeat ($urandom_range(2, 8)) begin
            level = 1'($urandom_range(1));
            repeat ($urandom_range(1, 40)) line_plan.push_back(level);
         end
         return;
      end
      // idle gap, sometimes none so frames run back to back
      if ($urandom_range(3) != 0)
         repeat ($urandom_range(1, 2 * bit_len)) line_plan.push_back(1'b1);
      if (roll < 90) begin
         // well formed frame; a ninth of them with a low stop bit
         frame = {(roll < 80), 8'($urandom_range(255)), 1'b0};
         bit_ticks = bit_len;
         if (bit_len > 3 && $urandom_range(9) < 3)
            bit_ticks = bit_len - 1 + $urandom_range(2);
         for (k = 0; k < 10; k++)
            repeat (bit_ticks) line_plan.push_back(frame[k]);
      end else begin
         // glitches, also landing inside a frame in progress
         repeat ($urandom_range(1, 3 * bit_len)) line_plan.push_back(1'(
            $urandom_range(1)));
      end
   endfunction

   // directed opening at period 0: field extremes, take and offers without take
   task automatic run_directed();
      int i;
      settle();
      write_period(16'd0);
      idle_mode = IDLE_NONE;
      for (i = 0; i < DIRECT_TICKS; i++)
         send_tick(DIRECT_PIN[i], DIRECT_OFFER[i],
                   (i == 13) ? 8'hA5 : (i[0] ? 8'h00 : 8'hFF));
   endtask

   // one setting of bit_period: framed traffic on rx, bursts of tx offers
   task automatic run_phase(input logic [TIMER_W-1:0] period, input int unsigned count,
                            input idle_mode_type mode, input bit squeeze);
      int unsigned n;
      int unsigned burst;
      logic        pin;
      logic        offer;
      settle();
      write_period(period);
      idle_mode = mode;
      line_plan.delete();
      burst = 0;
      for (n = 0; n < count; n++) begin
         if (line_plan.size() == 0)
            plan_line(period);
         pin = line_plan.pop_front();
         if (burst != 0) begin
            offer = 1'b1;
            burst--;
         end else begin
            offer = ($urandom_range(15) == 0);
            // sustained offers keep the transmitter streaming bytes
            if ($urandom_range(99) < 3)
               burst = $urandom_range(1, 24) * (period + 1);
         end
         // long response hold while ticks keep coming: the block fills and stalls
         if (squeeze && n == count / 3)
            hold_asks++;
         send_tick(pin, offer, 8'($urandom_range(255)));
      end
   endtask

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.rx_pin     = 1'b1;
      req_bus.tx_valid   = 1'b0;
      req_bus.tx_byte    = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.bit_period = RESET_PERIOD;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // rising periods through the top of the range, so until the last phase the timer never sits above a new top value
      run_phase(16'd0, 60, IDLE_BOTH, 1'b0);
      run_phase(16'd1, 100, IDLE_SEND, 1'b0);
      run_phase(16'd2, 150, IDLE_RECV, 1'b0);
      run_phase(16'd3, 250, IDLE_NONE, 1'b1);
      run_phase(16'd5, 200, IDLE_BOTH, 1'b0);
      run_phase(16'd7, 200, IDLE_SEND, 1'b0);
      run_phase(16'd9, 150, IDLE_RECV, 1'b0);
      run_phase(16'($urandom_range(9, 12)), 150, IDLE_BOTH, 1'b0);
      run_phase(16'($urandom_range(13, 40)), 200, IDLE_SEND, 1'b0);
      run_phase(16'($urandom_range(60, 90)), 150, IDLE_RECV, 1'b0);
      // reset value again: start edges and the first bits of a frame
      run_phase(RESET_PERIOD, 200, IDLE_NONE, 1'b0);
      // top of the range; a start edge leaves the receiver waiting mid frame
      run_phase(16'hFFFF, 80, IDLE_NONE, 1'b0);
      // lowered below the running timer: it counts on past the new top,
      // and the pending sample point lies above the new period
      run_phase(16'd4, 200, IDLE_NONE, 1'b0);

      settle();
      $display("covered %0d ticks over %0d bit period settings, 0, 1, 416 and 65535 among them",
               ticks_sent, settings_used);
      $display("%0d framed bytes received, %0d transmit bytes taken, %0d long response hold",
               rx_bytes_seen, tx_takes_seen, hold_asks);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

[files.f]
hdl/tbu_pkg.sv
hdl/tbu_if.sv
hdl/tbu_tx.sv
hdl/tbu_rx.sv
hdl/timer_based_uart_8n1.sv
sim/tbu_check.sv
sim/tb.sv
